// ===== rtl/stb_pkg.sv =====
// Shared types and constants for the software timer bank.
// No dependencies; imported by every module of the block.
package stb_pkg;

   localparam int TAG_W    = 8;
   localparam int HANDLE_W = 8;
   localparam int MS_W     = 32;
   localparam int TICKS_W  = 29;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;

   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_START  = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_TAG = 2'd2;

   localparam logic RESP_CREATE = 1'b0;
   localparam logic RESP_EXPIRY = 1'b1;

   // floor(x / 10) == (x * DIV10_MULT) >> DIV10_SHIFT for every 32-bit x
   localparam logic [MS_W-1:0] DIV10_MULT  = 32'hCCCC_CCCD;
   localparam int              DIV10_SHIFT = 35;

   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0,
      CMD_START  = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [TAG_W-1:0]    tag;
      logic [HANDLE_W-1:0] handle;
      logic [TICKS_W-1:0]  ticks;
   } cmd_type;

endpackage

// ===== rtl/stb_front.sv =====
// Front end: accepts request words, drops unknown codes and converts ms to ticks.
// Depends on stb_pkg; feeds stb_fifo.
module stb_front
   import stb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [47:0]   req_tdata,   // owner_tag[7:0], slot_handle[15:8], timeout_ms[47:16]
   input  logic [1:0]    req_tuser,   // req_type[1:0]
   output logic          cmd_valid,
   input  logic          cmd_ready,
   output cmd_type       cmd
);

   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          s1_type_ff;
   logic [TAG_W-1:0]    s1_tag_ff;
   logic [HANDLE_W-1:0] s1_handle_ff;
   logic [MS_W-1:0]     s1_ms_ff;
   logic                s2_valid_ff, s2_valid_in;
   cmd_type             s2_cmd_ff, s2_cmd_in;
   logic [2*MS_W-1:0]   prod;
   logic                s1_go;
   logic                s1_known;
   logic                req_take;

   assign s1_go      = s1_valid_ff && (!s2_valid_ff || cmd_ready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;
   assign prod       = (2*MS_W)'(s1_ms_ff) * (2*MS_W)'(DIV10_MULT);

   always_comb begin
      s1_known         = 1'b1;
      s2_cmd_in.tag    = s1_tag_ff;
      s2_cmd_in.handle = s1_handle_ff;
      s2_cmd_in.ticks  = prod[DIV10_SHIFT +: TICKS_W];
      unique case (s1_type_ff)
         REQ_CREATE: s2_cmd_in.kind = CMD_CREATE;
         REQ_START:  s2_cmd_in.kind = CMD_START;
         REQ_TICK:   s2_cmd_in.kind = CMD_TICK;
         default: begin
            s2_cmd_in.kind = CMD_TICK;
            s1_known       = 1'b0;
         end
      endcase
   end

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      if (s1_go) begin
         s2_valid_in = s1_known;
      end else if (cmd_ready) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff   <= req_tuser;
         s1_tag_ff    <= req_tdata[7:0];
         s1_handle_ff <= req_tdata[15:8];
         s1_ms_ff     <= req_tdata[47:16];
      end
      if (s1_go) begin
         s2_cmd_ff <= s2_cmd_in;
      end
   end

   assign cmd_valid = s2_valid_ff;
   assign cmd       = s2_cmd_ff;

endmodule

// ===== rtl/stb_fifo.sv =====
// Two-entry command queue between the front end and the slot engine.
// Depends on stb_pkg for cmd_type.
module stb_fifo
   import stb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  cmd_type wr_cmd,
   output logic    rd_valid,
   input  logic    rd_ready,
   output cmd_type rd_cmd
);

   localparam int DEPTH = 2;
   localparam int PTR_W = 1;

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             push, pop;

   assign wr_ready = count_ff != (PTR_W+1)'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// ===== rtl/stb_back.sv =====
// Slot engine: slot tables, allocation count, tick walk and the result register.
// Depends on stb_pkg; takes commands from stb_fifo.
module stb_back
   import stb_pkg::*;
#(
   parameter int SLOT_COUNT = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], slot_index[7:2], expired_tag[15:8]
   output logic [0:0]  rsp_tuser,   // resp_kind[0]
   output logic        rsp_tlast
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W = HANDLE_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_UPD   = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   // slots at or above base are owned; lower ones read as free and idle
   logic [TICKS_W-1:0] remain_mem [SLOT_COUNT];
   logic [TAG_W-1:0]   owner_mem  [SLOT_COUNT];

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   alloc_ff, alloc_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [TICKS_W-1:0] rd_remain_ff;
   logic [TAG_W-1:0]   rd_owner_ff;
   logic               hold_valid_ff, hold_valid_in;
   logic [IDX_W-1:0]   hold_slot_ff, hold_slot_in;
   logic [TAG_W-1:0]   hold_tag_ff, hold_tag_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic                rsp_last_ff, rsp_last_in;

   logic               out_free, push;
   logic [CNT_W-1:0]   base;
   logic [CNT_W-1:0]   new_slot;
   logic               wr_remain_en, wr_owner_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [TICKS_W-1:0] wr_remain;
   logic               start_ok;
   logic               expire;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign base      = CNT_W'(SLOT_COUNT) - alloc_ff;
   assign new_slot  = CNT_W'(SLOT_COUNT - 1) - alloc_ff;
   assign start_ok  = (CMP_W'(cmd.handle) < CMP_W'(SLOT_COUNT))
                      && (CMP_W'(cmd.handle) >= CMP_W'(base));
   assign expire    = rd_remain_ff == TICKS_W'(1);

   always_comb begin
      state_in      = state_ff;
      alloc_in      = alloc_ff;
      slot_in       = slot_ff;
      hold_valid_in = hold_valid_ff;
      hold_slot_in  = hold_slot_ff;
      hold_tag_in   = hold_tag_ff;
      cmd_ready     = 1'b0;
      push          = 1'b0;
      rsp_kind_in   = RESP_EXPIRY;
      rsp_status_in = ST_OK;
      rsp_slot_in   = SLOT_W'(hold_slot_ff);
      rsp_tag_in    = hold_tag_ff;
      rsp_last_in   = 1'b0;
      wr_remain_en  = 1'b0;
      wr_owner_en   = 1'b0;
      wr_addr       = slot_ff;
      wr_remain     = rd_remain_ff - TICKS_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_CREATE: begin
                     if (out_free) begin
                        cmd_ready   = 1'b1;
                        push        = 1'b1;
                        rsp_kind_in = RESP_CREATE;
                        rsp_tag_in  = '0;
                        rsp_slot_in = '0;
                        rsp_last_in = 1'b1;
                        if (cmd.tag == '0) begin
                           rsp_status_in = ST_ZERO_TAG;
                        end else if (alloc_ff == CNT_W'(SLOT_COUNT)) begin
                           rsp_status_in = ST_NO_FREE;
                        end else begin
                           rsp_slot_in  = SLOT_W'(new_slot);
                           wr_addr      = IDX_W'(new_slot);
                           wr_remain    = '0;
                           wr_remain_en = 1'b1;
                           wr_owner_en  = 1'b1;
                           alloc_in     = alloc_ff + 1'b1;
                        end
                     end
                  end
                  CMD_START: begin
                     cmd_ready    = 1'b1;
                     wr_addr      = IDX_W'(cmd.handle);
                     wr_remain    = cmd.ticks;
                     wr_remain_en = start_ok;
                  end
                  CMD_TICK: begin
                     cmd_ready     = 1'b1;
                     hold_valid_in = 1'b0;
                     slot_in       = IDX_W'(SLOT_COUNT - 1);
                     if (alloc_ff != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  default: cmd_ready = 1'b1;
               endcase
            end
         end
         ST_READ: state_in = ST_UPD;
         ST_UPD: begin
            if (!(expire && hold_valid_ff && !out_free)) begin
               wr_remain_en = rd_remain_ff != '0;
               if (expire) begin
                  push          = hold_valid_ff;
                  hold_valid_in = 1'b1;
                  hold_slot_in  = slot_ff;
                  hold_tag_in   = rd_owner_ff;
               end
               if (CNT_W'(slot_ff) == base) begin
                  state_in = ST_FLUSH;
               end else begin
                  slot_in  = slot_ff - 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = push ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         alloc_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alloc_ff      <= alloc_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      hold_slot_ff <= hold_slot_in;
      hold_tag_ff  <= hold_tag_in;
      if (push) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_remain_en) begin
         remain_mem[wr_addr] <= wr_remain;
      end
      if (wr_owner_en) begin
         owner_mem[wr_addr] <= cmd.tag;
      end
      if (state_ff == ST_READ) begin
         rd_remain_ff <= remain_mem[slot_ff];
         rd_owner_ff  <= owner_mem[slot_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_tag_ff, rsp_slot_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/software_timer_bank.sv =====
// Software timer bank top level: front end, command queue and slot engine.
// Depends on stb_pkg, stb_front, stb_fifo and stb_back.
//
// A bank of SLOT_COUNT one-shot timers counting 10 ms ticks. Create (req_type 0)
// claims the highest free slot and always returns one reply word; start (1)
// loads an owned slot with timeout_ms / 10 and returns nothing; tick (2) walks
// the owned slots from the top down and returns one expiry word per slot that
// reaches zero, tlast on the final one. Slots stay owned until reset. In the
// front end a request is registered at capture and after the divide-by-ten
// multiply, then queued. In the slot engine a tick reads each owned slot from
// the single-port slot tables and writes it back while it runs, and holds
// while an expiry word waits on rsp_tready. Reset is immediate, with no
// clearing pass: slots at or above SLOT_COUNT minus the fill count are the
// only ones ever read.
module software_timer_bank
   import stb_pkg::*;
#(
   parameter int SLOT_COUNT = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // owner_tag[7:0], slot_handle[15:8], timeout_ms[47:16]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], slot_index[7:2], expired_tag[15:8]
   output logic [0:0]  rsp_tuser,   // resp_kind[0]
   output logic        rsp_tlast
);

   logic    fr_valid, fr_ready;
   cmd_type fr_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   stb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (fr_valid),
      .cmd_ready  (fr_ready),
      .cmd        (fr_cmd)
   );

   stb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_cmd   (fr_cmd),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_cmd   (q_cmd)
   );

   stb_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
